// File: rtl/peer_heartbeat_monitor_macros.svh
// assertion macros used by the monitor rtl (phm_ctrl)
`ifndef PEER_HEARTBEAT_MONITOR_MACROS_SVH
`define PEER_HEARTBEAT_MONITOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define PHM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PHM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/phm_pkg.sv
`default_nettype none

package phm_pkg;

    localparam int MAX_PEERS = 16;
    localparam int SLOT_W    = $clog2(MAX_PEERS);
    localparam int COUNT_W   = $clog2(MAX_PEERS + 1);

    localparam logic [7:0] HDR_MARK_A = 8'hFF;
    localparam logic [7:0] HDR_MARK_B = 8'h7E;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_PACKET = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_RECONN = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam int         CFG_INDEX_W        = 1;
    localparam logic [0:0] REG_KEEPALIVE      = 1'd0;
    localparam logic [0:0] REG_PEER_COUNT     = 1'd1;

    // input item, packed to match the low bits of s_tdata
    typedef struct packed {
        logic [7:0]        subsystem;
        logic [SLOT_W-1:0] entry_index;
        logic [31:0]       source_ip;
        logic [15:0]       frame;
        logic [7:0]        byte1;
        logic [7:0]        byte0;
    } item_t;

    // one table entry as held in the ram
    typedef struct packed {
        logic [7:0]  code;
        logic [31:0] address;
        logic [15:0] countdown;
        logic        connected;
    } entry_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        code;
        logic [31:0]       address;
        logic              connected;
        logic              changed;
        logic [15:0]       frame;
        logic              last;
    } result_t;

    // ram access from the sequencer
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        entry_t            wdata;
        logic [SLOT_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// File: rtl/phm_ram.sv
`default_nettype none

module phm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/phm_obuf.sv
`default_nettype none

module phm_obuf
    import phm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         free,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [63:0]  m_tdata,  // peer_slot, peer_code, peer_address, is_connected,
                                   // status_changed, ack_frame, zero fill
    output logic [1:0]   m_tuser,  // kind
    output logic         m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.last;
    assign m_tdata  = {2'b00, data_reg.frame, data_reg.changed, data_reg.connected,
                       data_reg.address, data_reg.code, data_reg.slot};

endmodule

`default_nettype wire

// File: rtl/phm_ctrl.sv
`default_nettype none

`include "peer_heartbeat_monitor_macros.svh"

module phm_ctrl
    import phm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   in_mode,
    input  wire item_t        in_item,
    input  wire logic [15:0]  keepalive_ticks,
    input  wire logic [4:0]   peer_count,
    output ram_req_t          ram_req,
    input  wire entry_t       ram_rdata,
    input  wire logic         out_free,
    output logic              push,
    output result_t           push_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_PR   = 2'd2;
    localparam logic [1:0] ST_ACK  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [SLOT_W-1:0]  idx_reg;
    logic [SLOT_W-1:0]  idx_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               walk_tick_reg;
    logic               walk_tick_next;
    logic [31:0]        ip_reg;
    logic [31:0]        ip_next;
    logic [15:0]        frame_reg;
    logic [15:0]        frame_next;

    logic [COUNT_W-1:0] n_valid;
    logic               accept;
    logic               warn;
    logic               idx_last;
    logic               match;
    entry_t             upd;

    assign n_valid  = (peer_count > 5'(MAX_PEERS))
                      ? COUNT_W'(MAX_PEERS) : COUNT_W'(peer_count);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign warn     = ((in_item.byte0 == HDR_MARK_A) && (in_item.byte1 == HDR_MARK_B)) ||
                      ((in_item.byte0 == HDR_MARK_B) && (in_item.byte1 == HDR_MARK_A));
    assign idx_last = (COUNT_W'(idx_reg) + COUNT_W'(1)) == count_reg;
    assign match    = (ram_rdata.address == ip_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        walk_tick_next = walk_tick_reg;
        ip_next        = ip_reg;
        frame_next     = frame_reg;
        upd            = ram_rdata;
        ram_req.we     = 1'b0;
        ram_req.waddr  = idx_reg;
        ram_req.wdata  = ram_rdata;
        ram_req.raddr  = idx_reg;
        push           = 1'b0;
        push_data      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    count_next = n_valid;
                    ip_next    = in_item.source_ip;
                    frame_next = in_item.frame;
                    case (in_mode)
                        MODE_TICK:
                        begin
                            walk_tick_next = 1'b1;
                            if (n_valid != '0)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        MODE_PACKET:
                        begin
                            walk_tick_next = 1'b0;
                            if (warn)
                            begin
                                state_next = ST_ACK;
                            end
                            else if ((in_item.byte0 == HDR_MARK_A) && (n_valid != '0))
                            begin
                                state_next = ST_RD;
                            end
                        end
                        MODE_LOAD:
                        begin
                            if (COUNT_W'(in_item.entry_index) < COUNT_W'(MAX_PEERS))
                            begin
                                ram_req.we                = 1'b1;
                                ram_req.waddr             = in_item.entry_index;
                                ram_req.wdata.code        = in_item.subsystem;
                                ram_req.wdata.address     = in_item.source_ip;
                                ram_req.wdata.countdown   = keepalive_ticks;
                                ram_req.wdata.connected   = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_data.kind  = KIND_ACK;
                    push_data.frame = frame_reg;
                    push_data.last  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_RD:
            begin
                // read data for idx_reg arrives in the next cycle
                state_next = ST_PR;
            end
            ST_PR:
            begin
                if (walk_tick_reg)
                begin
                    if (ram_rdata.countdown != 16'd0)
                    begin
                        upd.countdown = ram_rdata.countdown - 16'd1;
                    end
                    else
                    begin
                        upd.connected = 1'b0;
                    end
                    if (out_free)
                    begin
                        ram_req.we          = 1'b1;
                        ram_req.wdata       = upd;
                        push                = 1'b1;
                        push_data.kind      = KIND_TICK;
                        push_data.slot      = idx_reg;
                        push_data.code      = ram_rdata.code;
                        push_data.address   = ram_rdata.address;
                        push_data.connected = upd.connected;
                        push_data.changed   = ram_rdata.connected && !upd.connected;
                        push_data.last      = idx_last;
                        idx_next            = idx_reg + SLOT_W'(1);
                        state_next          = idx_last ? ST_IDLE : ST_RD;
                    end
                end
                else if (match)
                begin
                    upd.countdown = keepalive_ticks;
                    upd.connected = 1'b1;
                    if (ram_rdata.connected || out_free)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.wdata = upd;
                        state_next    = ST_IDLE;
                        if (!ram_rdata.connected)
                        begin
                            push                = 1'b1;
                            push_data.kind      = KIND_RECONN;
                            push_data.slot      = idx_reg;
                            push_data.code      = ram_rdata.code;
                            push_data.address   = ram_rdata.address;
                            push_data.connected = 1'b1;
                            push_data.changed   = 1'b1;
                            push_data.last      = 1'b1;
                        end
                    end
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_W'(1);
                    state_next = idx_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_tick_reg <= walk_tick_next;
        ip_reg        <= ip_next;
        frame_reg     <= frame_next;
    end

    `PHM_ASSERT_IMPLY(a_push_state, clk, rst_n, push,
        (state_reg == ST_PR) || (state_reg == ST_ACK), "result pushed outside a result state")
    `PHM_ASSERT_IMPLY(a_push_free, clk, rst_n, push, out_free,
        "result pushed into a full output stage")
    `PHM_ASSERT_IMPLY(a_idx_range, clk, rst_n, (state_reg == ST_RD) || (state_reg == ST_PR),
        COUNT_W'(idx_reg) < count_reg, "walk index beyond valid entries")
    `PHM_ASSERT_NEXT(a_rd_to_pr, clk, rst_n, state_reg == ST_RD, state_reg == ST_PR,
        "read not followed by processing")

endmodule

`default_nettype wire

// File: rtl/peer_heartbeat_monitor.sv
// peer heartbeat monitor: keeps a 16-entry peer table (subsystem code, ipv4
// address, tick countdown, connected flag) in a single-port-write ram with a
// registered read, and works on one input transfer at a time. a load writes
// its entry in the cycle it is accepted. a tick walks entries 0 to
// min(peer_count,16)-1, each a ram read, then update, write-back and result,
// so it holds the input until the last entry is done, longer under output
// back-pressure. a keepalive frame searches the same way and stops at the
// first address match. a warning frame moves to an ack state, which pushes
// the ack into the output register once that register is free; the register
// then drives it on the result stream. the read/write pair per entry and
// output back-pressure set the rate; no two accesses to one entry ever overlap.
// results pass through a one-deep output register, so a new input transfer can
// be taken while a result waits.
// s_tuser carries the mode (0 tick, 1 packet, 2 load); m_tuser carries the
// result kind (0 warning ack, 1 reconnection, 2 tick keepalive report) and
// m_tlast marks the final result of an input item. configuration writes
// (register 0 keepalive_ticks, register 1 peer_count) belong in idle periods.
`default_nettype none

module peer_heartbeat_monitor
    import phm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [79:0]            s_tdata,  // header_byte0, header_byte1, frame_field,
                                                  // source_ip, entry_index, entry_subsystem,
                                                  // zero fill
    input  wire logic [1:0]             s_tuser,  // mode
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [63:0]                 m_tdata,  // peer_slot, peer_code, peer_address,
                                                  // is_connected, status_changed, ack_frame,
                                                  // zero fill
    output logic [1:0]                  m_tuser,  // kind
    output logic                        m_tlast,
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]            cfg_data
);

    logic [15:0] keepalive_ticks_reg;
    logic [4:0]  peer_count_reg;

    item_t       item;
    ram_req_t    ram_req;
    entry_t      ram_rdata;
    logic        out_free;
    logic        push;
    result_t     push_data;

    // configuration registers; writing them only while the block is idle is up to the user, unchecked by the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keepalive_ticks_reg <= 16'd3;
            peer_count_reg      <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEEPALIVE:  keepalive_ticks_reg <= cfg_data;
                REG_PEER_COUNT: peer_count_reg      <= cfg_data[4:0];
                default:        peer_count_reg      <= peer_count_reg;
            endcase
        end
    end

    // unpack the input transfer, upper fill bits unused
    assign item = item_t'(s_tdata[$bits(item_t)-1:0]);

    // sequencer: load writes, tick walk and keepalive search
    phm_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_mode         (s_tuser),
        .in_item         (item),
        .keepalive_ticks (keepalive_ticks_reg),
        .peer_count      (peer_count_reg),
        .ram_req         (ram_req),
        .ram_rdata       (ram_rdata),
        .out_free        (out_free),
        .push            (push),
        .push_data       (push_data)
    );

    // peer table
    phm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_PEERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // output register between the sequencer and the result stream
    phm_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
